// File: sv/mdbs_pkg.sv
// ----------------------------------------------------------------------------
// mdbs_pkg
// shared types and constants of the masked depth block store
// ----------------------------------------------------------------------------
`default_nettype none
package mdbs_pkg;
   localparam int MAX_BLOCKS_X_DEF = 64;
   localparam int MAX_BLOCKS_Y_DEF = 64;
   localparam int CFG_W = 7;
   localparam int CFG_IDX_W = 1;
   localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_WIDE = 1'b0;
   localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_HIGH = 1'b1;
   localparam logic signed [31:0] EMPTY_DEPTH = 32'sh8000_0000;
   localparam logic [31:0] FULL_MASK = 32'hFFFF_FFFF;

   localparam logic [2:0] OP_CLEAR  = 3'd0;
   localparam logic [2:0] OP_UPDATE = 3'd1;
   localparam logic [2:0] OP_QUERY  = 3'd2;
   localparam logic [2:0] OP_PIXEL  = 3'd3;
   localparam logic [2:0] OP_FLOOR  = 3'd4;

   localparam logic [1:0] VERDICT_VISIBLE  = 2'd0;
   localparam logic [1:0] VERDICT_OCCLUDED = 2'd1;
   localparam logic [1:0] VERDICT_OFFSCREEN = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic [5:0]         block_col;
      logic [5:0]         block_row;
      logic [31:0]        coverage;
      logic signed [31:0] depth_in;
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic signed [15:0] right;
      logic signed [15:0] bottom;
   } req_type;

   typedef struct packed {
      logic [1:0]         verdict;
      logic signed [31:0] depth_out;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture request and set up walk
      logic clr_start; // reset sweep address
      logic clr_write; // write one cleared entry
      logic rd;        // issue a memory read at the current address
      logic evaluate;  // data from read is valid: compute
      logic step;      // advance walk address
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic walk_last;
      logic hit;       // query found a visible block
      logic no_walk;   // op done without memory (offscreen, outside, no buffer)
   } sts_type;
endpackage
`default_nettype wire

// File: sv/mdbs_if.sv
// ----------------------------------------------------------------------------
// mdbs_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
`default_nettype none
interface mdbs_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/mdbs_datapath.sv
// ----------------------------------------------------------------------------
// mdbs_datapath
// block memories, address walk, update merge and query compare
// ----------------------------------------------------------------------------
`default_nettype none
module mdbs_datapath #(
   parameter int MAX_BLOCKS_X = mdbs_pkg::MAX_BLOCKS_X_DEF,
   parameter int MAX_BLOCKS_Y = mdbs_pkg::MAX_BLOCKS_Y_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [0:0]            csr_index,
   input  wire logic [6:0]            csr_data,
   input  wire mdbs_pkg::req_type     req,
   input  wire mdbs_pkg::cmd_type     cmd,
   output mdbs_pkg::sts_type          sts,
   output mdbs_pkg::rsp_type          rsp
);
   localparam int XW = (MAX_BLOCKS_X > 1) ? $clog2(MAX_BLOCKS_X) : 1;
   localparam int YW = (MAX_BLOCKS_Y > 1) ? $clog2(MAX_BLOCKS_Y) : 1;
   localparam int AW = XW + YW;
   localparam int DEPTH = (1 << AW);

   // block memories
   logic signed [31:0] floor_mem [DEPTH];
   logic signed [31:0] layer_mem [DEPTH];
   logic [31:0]        mask_mem  [DEPTH];

   logic [6:0] wide_ff, high_ff;
   mdbs_pkg::req_type req_ff;
   logic [XW-1:0] bx_ff, bx0_ff, bx1_ff;
   logic [YW-1:0] by_ff, by1_ff;
   logic [AW-1:0] clr_ff;
   logic signed [31:0] rd_floor_ff, rd_layer_ff;
   logic [31:0] rd_mask_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [31:0] pix_bit_ff;
   logic no_walk_ff, hit_ff;
   mdbs_pkg::rsp_type rsp_in;

   // saturate a written grid size
   function automatic logic [6:0] sat(input logic [6:0] v, input int m);
      logic [6:0] r;
      r = (32'(v) > m) ? 7'(m) : v;
      return r;
   endfunction

   // setup of the request
   logic signed [17:0] x0, y0, x1, y1, bufw, bufh, xr1, yb1;
   logic buf_none, off, pix_in;
   logic signed [17:0] cx0, cy0, cx1, cy1;
   always_comb begin
      bufw = 18'(signed'({1'b0, wide_ff, 3'b000}));
      bufh = 18'(signed'({1'b0, high_ff, 2'b00}));
      x0 = 18'(req.left);
      y0 = 18'(req.top);
      xr1 = 18'(req.right) - 18'sd1;
      yb1 = 18'(req.bottom) - 18'sd1;
      x1 = (xr1 < x0) ? x0 : xr1;
      y1 = (yb1 < y0) ? y0 : yb1;
      buf_none = (wide_ff == 7'd0) || (high_ff == 7'd0);
      off = (x1 < 0) || (y1 < 0) || (x0 >= bufw) || (y0 >= bufh);
      cx0 = (x0 < 0) ? 18'sd0 : x0;
      cy0 = (y0 < 0) ? 18'sd0 : y0;
      cx1 = (x1 > bufw - 18'sd1) ? bufw - 18'sd1 : x1;
      cy1 = (y1 > bufh - 18'sd1) ? bufh - 18'sd1 : y1;
      pix_in = !buf_none && (x0 >= 0) && (y0 >= 0) && (x0 < bufw) && (y0 < bufh);
   end

   // floor of the block just read
   logic signed [31:0] blk_floor;
   always_comb begin
      if (rd_mask_ff == 32'd0)
         blk_floor = rd_floor_ff;
      else if (rd_mask_ff == mdbs_pkg::FULL_MASK)
         blk_floor = rd_layer_ff;
      else
         blk_floor = (rd_floor_ff < rd_layer_ff) ? rd_floor_ff : rd_layer_ff;
   end

   // update merge
   logic signed [33:0] lhs, rhs;
   logic upd_go, discard;
   logic [31:0] new_mask;
   logic signed [31:0] new_layer, new_floor;
   always_comb begin
      lhs = {rd_layer_ff[31], rd_layer_ff, 1'b0};
      rhs = 34'(req_ff.depth_in) + 34'(rd_floor_ff);
      upd_go = req_ff.depth_in > rd_floor_ff;
      discard = (rd_mask_ff == 32'd0) || (req_ff.coverage == mdbs_pkg::FULL_MASK) ||
                (lhs < rhs);
      new_floor = rd_floor_ff;
      if (discard) begin
         new_mask = req_ff.coverage;
         new_layer = req_ff.depth_in;
      end else begin
         new_mask = rd_mask_ff | req_ff.coverage;
         new_layer = (req_ff.depth_in < rd_layer_ff) ? req_ff.depth_in : rd_layer_ff;
      end
      if (new_mask == mdbs_pkg::FULL_MASK) begin
         new_floor = new_layer;
         new_mask = 32'd0;
         new_layer = mdbs_pkg::EMPTY_DEPTH;
      end
   end

   // memory port
   logic we;
   logic [AW-1:0] waddr;
   logic signed [31:0] wfloor, wlayer;
   logic [31:0] wmask;
   always_comb begin
      we = 1'b0;
      waddr = rd_addr_ff;
      wfloor = new_floor;
      wlayer = new_layer;
      wmask = new_mask;
      if (cmd.clr_write) begin
         we = 1'b1;
         waddr = clr_ff;
         wfloor = mdbs_pkg::EMPTY_DEPTH;
         wlayer = mdbs_pkg::EMPTY_DEPTH;
         wmask = 32'd0;
      end else if (cmd.evaluate && req_ff.opcode == mdbs_pkg::OP_UPDATE && upd_go) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         floor_mem[waddr] <= wfloor;
         layer_mem[waddr] <= wlayer;
         mask_mem[waddr]  <= wmask;
      end
      if (cmd.rd) begin
         rd_floor_ff <= floor_mem[{by_ff, bx_ff}];
         rd_layer_ff <= layer_mem[{by_ff, bx_ff}];
         rd_mask_ff  <= mask_mem[{by_ff, bx_ff}];
         rd_addr_ff  <= {by_ff, bx_ff};
      end
   end

   // walk bounds and control registers
   logic [31:0] pbit;
   always_comb pbit = 32'd1 << {y0[1:0], x0[2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= sat(7'd64, MAX_BLOCKS_X);
         high_ff <= sat(7'd64, MAX_BLOCKS_Y);
         clr_ff <= '0;
         hit_ff <= 1'b0;
         no_walk_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            if (csr_index == mdbs_pkg::REG_BLOCKS_WIDE)
               wide_ff <= sat(csr_data, MAX_BLOCKS_X);
            else
               high_ff <= sat(csr_data, MAX_BLOCKS_Y);
         end
         if (cmd.clr_start)
            clr_ff <= '0;
         else if (cmd.clr_write)
            clr_ff <= clr_ff + 1'b1;
         if (cmd.load) begin
            hit_ff <= 1'b0;
            unique case (req.opcode)
               mdbs_pkg::OP_UPDATE:
                  no_walk_ff <= (7'(req.block_col) >= wide_ff) ||
                                (7'(req.block_row) >= high_ff);
               mdbs_pkg::OP_QUERY: no_walk_ff <= buf_none || off;
               mdbs_pkg::OP_PIXEL, mdbs_pkg::OP_FLOOR: no_walk_ff <= !pix_in;
               default: no_walk_ff <= 1'b1;
            endcase
         end else if (cmd.evaluate && blk_floor <= req_ff.depth_in) begin
            hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         pix_bit_ff <= pbit;
         if (req.opcode == mdbs_pkg::OP_UPDATE) begin
            bx_ff <= XW'(req.block_col);
            by_ff <= YW'(req.block_row);
            bx0_ff <= XW'(req.block_col);
            bx1_ff <= XW'(req.block_col);
            by1_ff <= YW'(req.block_row);
         end else if (req.opcode == mdbs_pkg::OP_QUERY) begin
            bx_ff <= XW'(cx0 >>> 3);
            bx0_ff <= XW'(cx0 >>> 3);
            by_ff <= YW'(cy0 >>> 2);
            bx1_ff <= XW'(cx1 >>> 3);
            by1_ff <= YW'(cy1 >>> 2);
         end else begin
            bx_ff <= XW'(x0 >>> 3);
            bx0_ff <= XW'(x0 >>> 3);
            bx1_ff <= XW'(x0 >>> 3);
            by_ff <= YW'(y0 >>> 2);
            by1_ff <= YW'(y0 >>> 2);
         end
      end else if (cmd.step) begin
         if (bx_ff == bx1_ff) begin
            bx_ff <= bx0_ff;
            by_ff <= by_ff + 1'b1;
         end else begin
            bx_ff <= bx_ff + 1'b1;
         end
      end
   end

   // result forming
   always_comb begin
      rsp_in.verdict = mdbs_pkg::VERDICT_VISIBLE;
      rsp_in.depth_out = 32'sd0;
      case (req_ff.opcode)
         mdbs_pkg::OP_QUERY: begin
            if (no_walk_ff)
               rsp_in.verdict = buf_none ? mdbs_pkg::VERDICT_VISIBLE
                                         : mdbs_pkg::VERDICT_OFFSCREEN;
            else
               rsp_in.verdict = hit_ff ? mdbs_pkg::VERDICT_VISIBLE
                                       : mdbs_pkg::VERDICT_OCCLUDED;
         end
         mdbs_pkg::OP_PIXEL:
            rsp_in.depth_out = no_walk_ff ? mdbs_pkg::EMPTY_DEPTH :
               (((rd_mask_ff & pix_bit_ff) != 32'd0) ? rd_layer_ff : rd_floor_ff);
         mdbs_pkg::OP_FLOOR:
            rsp_in.depth_out = no_walk_ff ? mdbs_pkg::EMPTY_DEPTH : blk_floor;
         default: ;
      endcase
   end

   assign rsp = rsp_in;
   assign sts.clr_last = (clr_ff == AW'(DEPTH - 1));
   assign sts.walk_last = (bx_ff == bx1_ff) && (by_ff == by1_ff);
   assign sts.hit = hit_ff || (cmd.evaluate && blk_floor <= req_ff.depth_in);
   assign sts.no_walk = no_walk_ff;
endmodule
`default_nettype wire

// File: sv/mdbs_ctrl.sv
// ----------------------------------------------------------------------------
// mdbs_ctrl
// sequencer for clear sweep, block walk and result handoff
// ----------------------------------------------------------------------------
`default_nettype none
module mdbs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write,
   input  wire logic               req_valid,
   input  wire logic [2:0]         req_opcode,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire mdbs_pkg::sts_type  sts,
   output mdbs_pkg::cmd_type       cmd,
   output logic                    rsp_load
);
   typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_SETUP, S_READ, S_EVAL, S_DONE} state_type;
   state_type state_ff;
   logic rsp_valid_ff;
   logic rsp_free;
   logic pend_clr_ff;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && !csr_write;
   assign rsp_valid = rsp_valid_ff;

   // command decode per state
   always_comb begin
      cmd = '0;
      rsp_load = 1'b0;
      cmd.load = req_valid && req_ready;
      cmd.clr_start = csr_write ||
                      (req_valid && req_ready && req_opcode == mdbs_pkg::OP_CLEAR);
      cmd.clr_write = (state_ff == S_CLEAR);
      cmd.rd = (state_ff == S_SETUP && !sts.no_walk) || (state_ff == S_READ);
      cmd.evaluate = (state_ff == S_EVAL);
      cmd.step = (state_ff == S_EVAL);
      rsp_load = (state_ff == S_DONE) && rsp_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            state_ff <= S_CLEAR;
         end else begin
            unique case (state_ff)
               // clear request still returns one result once the sweep ends
               S_CLEAR: if (sts.clr_last) state_ff <= pend_clr_ff ? S_DONE : S_IDLE;
               S_IDLE: if (req_valid)
                  state_ff <= (req_opcode == mdbs_pkg::OP_CLEAR) ? S_CLEAR : S_SETUP;
               S_SETUP: state_ff <= sts.no_walk ? S_DONE : S_EVAL;
               S_READ: state_ff <= S_EVAL;
               S_EVAL: state_ff <= (sts.walk_last || sts.hit) ? S_DONE : S_READ;
               S_DONE: if (rsp_free) state_ff <= S_IDLE;
               default: state_ff <= S_IDLE;
            endcase
         end
      end
   end

   // pending result for a clear operation
   always_ff @(posedge clock) begin
      if (reset || csr_write) pend_clr_ff <= 1'b0;
      else if (cmd.load && req_opcode == mdbs_pkg::OP_CLEAR) pend_clr_ff <= 1'b1;
      else if (rsp_load) pend_clr_ff <= 1'b0;
   end
endmodule
`default_nettype wire

// File: sv/masked_depth_block_store.sv
// clear sweep: after reset, any csr write or a clear (one block a cycle)
// update, pixel and floor reads: setup, memory read, evaluate, done; setup goes to done without memory
// rect query: reads and evaluates each block walked, stops on the first visible block
// one item at a time; next transfer in once the result registers
// reset is synchronous; it starts the clear sweep, no requests taken meanwhile
// ----------------------------------------------------------------------------
// masked_depth_block_store
// top level: grid of 8x4 pixel depth blocks with masked two-layer merge
// ----------------------------------------------------------------------------
`default_nettype none
module masked_depth_block_store #(
   parameter int MAX_BLOCKS_X = mdbs_pkg::MAX_BLOCKS_X_DEF,
   parameter int MAX_BLOCKS_Y = mdbs_pkg::MAX_BLOCKS_Y_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mdbs_if.sink             req_chan,
   mdbs_if.source           rsp_chan,
   input  wire logic        csr_write,
   input  wire logic [0:0]  csr_index,
   input  wire logic [6:0]  csr_data
);
   mdbs_pkg::cmd_type cmd;
   mdbs_pkg::sts_type sts;
   mdbs_pkg::rsp_type rsp_next;
   mdbs_pkg::rsp_type rsp_ff;
   logic rsp_load;
   mdbs_pkg::req_type req_payload;

   assign req_payload = req_chan.payload;

   mdbs_ctrl u_ctrl (
      .clock, .reset, .csr_write,
      .req_valid(req_chan.valid), .req_opcode(req_payload.opcode),
      .req_ready(req_chan.ready), .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready), .sts, .cmd, .rsp_load
   );

   mdbs_datapath #(.MAX_BLOCKS_X(MAX_BLOCKS_X), .MAX_BLOCKS_Y(MAX_BLOCKS_Y)) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .req(req_payload), .cmd, .sts, .rsp(rsp_next)
   );

   // result register
   always_ff @(posedge clock) begin
      if (rsp_load) rsp_ff <= rsp_next;
   end
   assign rsp_chan.payload = rsp_ff;
endmodule
`default_nettype wire

// File: sv/mdbs_checker.sv
// ----------------------------------------------------------------------------
// mdbs_checker
// port level checks of the masked depth block store
// ----------------------------------------------------------------------------
`default_nettype none
module mdbs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_verdict,
   input wire logic csr_write
);
   // result verdict held while stalled
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_verdict))
      else $error("result changed while stalled");
   // verdict never uses the spare code
   a_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict != 2'd3)
      else $error("bad verdict");
   // no request taken in the cycle after reset
   a_reset: assert property (@(posedge clock) $fell(reset) |-> !req_ready)
      else $error("ready right after reset");
   // result held while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");
   // no transfer during a csr write
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_write |-> !req_ready)
      else $error("request taken during csr write");
endmodule

bind masked_depth_block_store mdbs_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_chan.valid), .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid), .rsp_ready(rsp_chan.ready),
   .rsp_verdict(rsp_chan.payload.verdict), .csr_write(csr_write)
);
`default_nettype wire

// File: verif/tb_masked_depth_block_store.sv
// ----------------------------------------------------------------------------
// tb_masked_depth_block_store
// self-checking bench for the masked depth block store: random bursts of
// clears, merges, rect queries and depth reads over several grid sizes,
// checked transfer by transfer against a behavioral copy of the store
// ----------------------------------------------------------------------------
`default_nettype none
module tb_masked_depth_block_store;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_X = 64;
   localparam int GRID_Y = 64;
   localparam int NBLK = GRID_X * GRID_Y;
   localparam int REQ_W = $bits(mdbs_pkg::req_type);
   localparam logic [2:0] OP_SPARE5 = 3'd5;
   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = '0;
   logic [6:0] csr_data = '0;

   mdbs_if #(.PAYLOAD_TYPE(mdbs_pkg::req_type)) req_chan ();
   mdbs_if #(.PAYLOAD_TYPE(mdbs_pkg::rsp_type)) rsp_chan ();

   masked_depth_block_store uut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // behavioral copy of the block store
   logic signed [31:0] blk_floor [NBLK];
   logic signed [31:0] blk_layer [NBLK];
   logic [31:0]        blk_mask [NBLK];
   int grid_w = 64;
   int grid_h = 64;

   mdbs_pkg::req_type pending_reqs[$];
   mdbs_pkg::rsp_type expected_rsps[$];
   int fails = 0;
   int rsp_seen = 0;
   bit req_taken = 0;

   // append one item to the driver queue
   function automatic void queue_req(mdbs_pkg::req_type r);
      pending_reqs.insert(pending_reqs.size(), r);
   endfunction

   function automatic void wipe_store();
      for (int i = 0; i < NBLK; i++) begin
         blk_floor[i] = mdbs_pkg::EMPTY_DEPTH;
         blk_layer[i] = mdbs_pkg::EMPTY_DEPTH;
         blk_mask[i] = '0;
      end
   endfunction

   function automatic logic signed [31:0] floor_of(int i);
      if (blk_mask[i] == '0) return blk_floor[i];
      if (blk_mask[i] == mdbs_pkg::FULL_MASK) return blk_layer[i];
      return (blk_floor[i] < blk_layer[i]) ? blk_floor[i] : blk_layer[i];
   endfunction

   // two-layer merge of one triangle into one block
   function automatic void merge_cover(int bx, int by, logic [31:0] cov,
                                       logic signed [31:0] z);
      int i;
      bit discard;
      if (bx >= grid_w || by >= grid_h) return;
      i = by * GRID_X + bx;
      if (z <= blk_floor[i]) return;
      discard = blk_mask[i] == '0 || cov == mdbs_pkg::FULL_MASK ||
                2 * longint'(blk_layer[i]) < longint'(z) + longint'(blk_floor[i]);
      if (discard) begin
         blk_mask[i] = cov;
         blk_layer[i] = z;
      end else begin
         blk_mask[i] = blk_mask[i] | cov;
         if (z < blk_layer[i]) blk_layer[i] = z;
      end
      if (blk_mask[i] == mdbs_pkg::FULL_MASK) begin
         blk_floor[i] = blk_layer[i];
         blk_mask[i] = '0;
         blk_layer[i] = mdbs_pkg::EMPTY_DEPTH;
      end
   endfunction

   function automatic logic [1:0] probe_rect(int x0, int y0, int xr, int yb,
                                             logic signed [31:0] znear);
      int bufw, bufh, x1, y1;
      bufw = grid_w * 8;
      bufh = grid_h * 4;
      x1 = xr - 1;
      y1 = yb - 1;
      if (grid_w == 0 || grid_h == 0) return mdbs_pkg::VERDICT_VISIBLE;
      if (x1 < x0) x1 = x0;
      if (y1 < y0) y1 = y0;
      if (x1 < 0 || y1 < 0 || x0 >= bufw || y0 >= bufh)
         return mdbs_pkg::VERDICT_OFFSCREEN;
      if (x0 < 0) x0 = 0;
      if (y0 < 0) y0 = 0;
      if (x1 > bufw - 1) x1 = bufw - 1;
      if (y1 > bufh - 1) y1 = bufh - 1;
      for (int by = y0 / 4; by <= y1 / 4; by++)
         for (int bx = x0 / 8; bx <= x1 / 8; bx++)
            if (floor_of(by * GRID_X + bx) <= znear) return mdbs_pkg::VERDICT_VISIBLE;
      return mdbs_pkg::VERDICT_OCCLUDED;
   endfunction

   function automatic bit pixel_in_grid(int x, int y);
      return grid_w != 0 && grid_h != 0 && x >= 0 && y >= 0 &&
             x < grid_w * 8 && y < grid_h * 4;
   endfunction

   // apply one request to the store copy and return its result
   function automatic mdbs_pkg::rsp_type apply_req(mdbs_pkg::req_type r);
      mdbs_pkg::rsp_type o;
      int x, y, i;
      o = '0;
      x = r.left;
      y = r.top;
      i = (y / 4) * GRID_X + (x / 8);
      case (r.opcode)
         mdbs_pkg::OP_CLEAR: wipe_store();
         mdbs_pkg::OP_UPDATE:
            merge_cover(r.block_col, r.block_row, r.coverage, r.depth_in);
         mdbs_pkg::OP_QUERY: o.verdict = probe_rect(x, y, r.right, r.bottom, r.depth_in);
         mdbs_pkg::OP_PIXEL: begin
            o.depth_out = mdbs_pkg::EMPTY_DEPTH;
            if (pixel_in_grid(x, y))
               o.depth_out = blk_mask[i][(y % 4) * 8 + (x % 8)] ? blk_layer[i]
                                                                  : blk_floor[i];
         end
         mdbs_pkg::OP_FLOOR: begin
            o.depth_out = mdbs_pkg::EMPTY_DEPTH;
            if (pixel_in_grid(x, y)) o.depth_out = floor_of(i);
         end
         default: ;
      endcase
      return o;
   endfunction

   // depths crowded together so ties and layer decisions happen
   function automatic logic signed [31:0] pick_depth();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return mdbs_pkg::EMPTY_DEPTH;
         2: return 32'sh7FFF_FFFF;
         default: return ($signed($urandom_range(0, 15)) - 8) <<< 14;
      endcase
   endfunction

   function automatic logic [31:0] pick_cover();
      case ($urandom_range(0, 7))
         0: return mdbs_pkg::FULL_MASK;
         1: return 32'h0;
         2: return 32'hFF << (8 * $urandom_range(0, 3));
         3: return 32'h1 << $urandom_range(0, 31);
         4: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic int near_span(int lim);
      return $urandom_range(0, lim + 6) - 3;
   endfunction

   function automatic mdbs_pkg::req_type make_req();
      mdbs_pkg::req_type r;
      int k, w;
      r = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
      k = $urandom_range(0, 199);
      if (k < 2) r.opcode = mdbs_pkg::OP_CLEAR;
      else if (k < 90) r.opcode = mdbs_pkg::OP_UPDATE;
      else if (k < 140) r.opcode = mdbs_pkg::OP_QUERY;
      else if (k < 165) r.opcode = mdbs_pkg::OP_PIXEL;
      else if (k < 190) r.opcode = mdbs_pkg::OP_FLOOR;
      else r.opcode = 3'($urandom_range(5, 7));
      r.depth_in = pick_depth();
      if (r.opcode == mdbs_pkg::OP_UPDATE) begin
         r.coverage = pick_cover();
         if ($urandom_range(0, 9) != 0) begin
            w = (grid_w > 4) ? 4 : grid_w;
            r.block_col = 6'($urandom_range(0, w));
            w = (grid_h > 3) ? 3 : grid_h;
            r.block_row = 6'($urandom_range(0, w));
         end
      end else if ($urandom_range(0, 49) != 0) begin
         r.left = 16'(near_span(grid_w * 8));
         r.top = 16'(near_span(grid_h * 4));
         if (r.opcode == mdbs_pkg::OP_QUERY) begin
            r.right = 16'(int'(r.left) + $urandom_range(0, 24) - 3);
            r.bottom = 16'(int'(r.top) + $urandom_range(0, 12) - 3);
         end else if (r.left >= 0 && r.top >= 0 && $urandom_range(0, 1)) begin
            // aim reads at the blocks that updates hit
            r.left = 16'($urandom_range(0, 39));
            r.top = 16'($urandom_range(0, 15));
         end
      end
      return r;
   endfunction

   // request driver: bursts with gaps, holds an offer until transfer
   int gap_left = 0;
   int burst_left = 4;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         req_chan.valid <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         req_chan.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
         req_chan.payload <= pending_reqs[0];
         req_chan.valid <= 1'b1;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end else begin
         req_chan.valid <= 1'b0;
      end
   end

   // response ready: changing stall modes plus one long hold-off
   int ready_mode = 0;
   int mode_left = 0;
   int hold_off = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left = $urandom_range(20, 120);
      end else begin
         mode_left--;
      end
      if (!hold_done && rsp_seen >= 400) begin
         hold_done = 1;
         hold_off = 300;
      end
      if (hold_off > 0) begin
         hold_off--;
         rsp_chan.ready <= 1'b0;
      end else begin
         case (ready_mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= ($urandom_range(0, 7) != 0);
            default: rsp_chan.ready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // monitor: predict on request transfer, compare on response transfer
   always @(posedge clock) begin
      req_taken = 0;
      if (!reset && req_chan.valid && req_chan.ready) begin
         req_taken = 1;
         expected_rsps.insert(expected_rsps.size(), apply_req(req_chan.payload));
         void'(pending_reqs.pop_front());
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            fails++;
            $display("%0t: unexpected result exp none act verdict %0d depth %h", $time,
                     rsp_chan.payload.verdict, rsp_chan.payload.depth_out);
         end else begin
            mdbs_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_chan.payload.verdict !== e.verdict) begin
               fails++;
               $display("%0t: verdict exp %0d act %0d", $time, e.verdict,
                        rsp_chan.payload.verdict);
            end
            if (rsp_chan.payload.depth_out !== e.depth_out) begin
               fails++;
               $display("%0t: depth_out exp %h act %h", $time, e.depth_out,
                        rsp_chan.payload.depth_out);
            end
         end
      end
   end

   task automatic settle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(logic [0:0] idx, logic [6:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      if (idx == mdbs_pkg::REG_BLOCKS_WIDE) grid_w = (val > GRID_X) ? GRID_X : val;
      else grid_h = (val > GRID_Y) ? GRID_Y : val;
      wipe_store();
   endtask

   function automatic mdbs_pkg::req_type dir_req(logic [2:0] op, int col, int row,
                                                 logic [31:0] cov, logic signed [31:0] z,
                                                 int l, int t, int r, int b);
      mdbs_pkg::req_type q;
      q = '{op, 6'(col), 6'(row), cov, z, 16'(l), 16'(t), 16'(r), 16'(b)};
      return q;
   endfunction

   int phase_w[8] = '{3, 0, 6, 127, 1, 64, 10, 64};
   int phase_h[8] = '{2, 5, 0, 127, 1, 1, 7, 64};

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      wipe_store();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: merges, reads, each query outcome, spare opcodes
      queue_req(dir_req(mdbs_pkg::OP_UPDATE, 0, 0, 32'h0000_00FF, 32'sh0002_0000,
                        0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_UPDATE, 0, 0, 32'h0000_FF00, 32'sh0001_0000,
                        0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_PIXEL, 0, 0, 0, 0, 3, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_PIXEL, 0, 0, 0, 0, 3, 3, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_UPDATE, 0, 0, 32'hFFFF_0000, 32'sh0001_8000,
                        0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_FLOOR, 0, 0, 0, 0, 7, 3, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_UPDATE, 1, 0, mdbs_pkg::FULL_MASK, 32'sh7FFF_FFFF,
                        0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_UPDATE, 63, 63, mdbs_pkg::FULL_MASK, 32'sh0000_0001,
                        0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 32'sh0001_0000, 0, 0, 8, 4));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 32'sh0000_0000, 0, 0, 8, 4));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 32'sh0000_0000, 12, 2, 5, -1));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 0, 512, 0, 600, 4));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 0, -40, -40, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_QUERY, 0, 0, 0, 32'sh8000_0000,
                        -32768, -32768, 32767, 32767));
      queue_req(dir_req(mdbs_pkg::OP_PIXEL, 0, 0, 0, 0, -1, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_FLOOR, 0, 0, 0, 0, 511, 256, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_FLOOR, 0, 0, 0, 0, 511, 255, 0, 0));
      queue_req(dir_req(OP_SPARE5, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_req(dir_req(OP_SPARE6, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_req(dir_req(OP_SPARE7, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
      queue_req(dir_req(mdbs_pkg::OP_FLOOR, 0, 0, 0, 0, 8, 0, 0, 0));
      for (int n = 0; n < 180; n++) queue_req(make_req());
      settle();

      // grid sizes, each followed by random traffic; sender waits in between
      foreach (phase_w[p]) begin
         write_reg(mdbs_pkg::REG_BLOCKS_WIDE, 7'(phase_w[p]));
         write_reg(mdbs_pkg::REG_BLOCKS_HIGH, 7'(phase_h[p]));
         if (p == 0)
            queue_req(dir_req(mdbs_pkg::OP_UPDATE, 5, 1, mdbs_pkg::FULL_MASK,
                              32'sh0000_1000, 0, 0, 0, 0));
         for (int n = 0; n < 165; n++) queue_req(make_req());
         settle();
      end

      repeat (50) @(posedge clock);
      if (fails == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire
